[rtl/dtwfb_pkg.sv]
// Shared types and constants for the tuning-word frame builder.
package dtwfb_pkg;

    localparam int FREQ_W = 32;
    localparam int AMP_W  = 12;
    localparam int STEP_W = 24;
    localparam int TW_W   = 48;
    localparam int PROD_W = FREQ_W + STEP_W;
    localparam int IDX_W  = 4;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd938250;

    // Serial-port instruction bytes
    localparam logic [7:0] INSTR_FREQ    = 8'h02;
    localparam logic [7:0] INSTR_SHAPE_I = 8'h08;
    localparam logic [7:0] INSTR_SHAPE_Q = 8'h09;

    // Byte positions within a frame
    localparam logic [IDX_W-1:0] POS_FREQ_INSTR = 4'd0;
    localparam logic [IDX_W-1:0] POS_TW_FIRST   = 4'd1;
    localparam logic [IDX_W-1:0] POS_TW_LAST    = 4'd6;
    localparam logic [IDX_W-1:0] POS_SHAPE_I    = 4'd7;
    localparam logic [IDX_W-1:0] POS_AMP_HI_I   = 4'd8;
    localparam logic [IDX_W-1:0] POS_AMP_LO_I   = 4'd9;
    localparam logic [IDX_W-1:0] POS_SHAPE_Q    = 4'd10;
    localparam logic [IDX_W-1:0] POS_AMP_HI_Q   = 4'd11;
    localparam logic [IDX_W-1:0] POS_AMP_LO_Q   = 4'd12;
    localparam logic [IDX_W-1:0] POS_LAST       = POS_AMP_LO_Q;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } rsp_t;

    // One queued frame: computed tuning word plus amplitude
    typedef struct packed {
        logic [TW_W-1:0]  tuning_word;
        logic [AMP_W-1:0] amplitude;
    } frame_t;

endpackage

[rtl/dtwfb_front.sv]
// Front end: request register, step-factor register and tuning-word multiply.
module dtwfb_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  dtwfb_pkg::req_t                req,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dtwfb_pkg::STEP_W-1:0]   cfg_data,
    output logic                           push_valid,
    input  logic                           push_ready,
    output dtwfb_pkg::frame_t              push_data
);
    import dtwfb_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    req_t              s1_reg;
    logic [PROD_W-1:0] product;

    assign cfg_ready = 1'b1;
    assign req_ready = !s1_valid_reg || push_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_ready)
        begin
            s1_valid_next = req_valid;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_reg <= req;
        end
    end

    // Full 56-bit product, low 48 bits kept (wraps on overflow)
    assign product = PROD_W'(s1_reg.frequency) * PROD_W'(step_reg);

    assign push_valid            = s1_valid_reg;
    assign push_data.tuning_word = product[TW_W-1:0];
    assign push_data.amplitude   = s1_reg.amplitude;

endmodule

[rtl/dtwfb_queue.sv]
// Small register FIFO that decouples the front end from the byte sequencer.
module dtwfb_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  dtwfb_pkg::frame_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output dtwfb_pkg::frame_t pop_data
);
    import dtwfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_t            store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    // Pointers coincide whenever the queue is empty or full
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_FULL) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/dtwfb_back.sv]
// Back end: walks the head frame byte by byte into the response register.
module dtwfb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    output logic              head_pop,
    input  dtwfb_pkg::frame_t head,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dtwfb_pkg::rsp_t   rsp
);
    import dtwfb_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             load;
    logic             emit;
    logic [5:0]       tw_shift;
    logic [7:0]       amp_hi;
    logic [7:0]       amp_lo;

    assign load     = !rsp_valid_reg || rsp_ready;
    assign emit     = head_valid && load;
    assign head_pop = emit && (idx_reg == POS_LAST);

    assign amp_hi   = 8'(head.amplitude[AMP_W-1:8]);
    assign amp_lo   = head.amplitude[7:0];
    // Tuning-word bytes go out most significant first; byte distance times 8
    assign tw_shift = {3'(POS_TW_LAST - idx_reg), 3'b000};

    always_comb
    begin
        rsp_next.frame_end = (idx_reg == POS_LAST);
        case (idx_reg) inside
            POS_FREQ_INSTR:              rsp_next.out_byte = INSTR_FREQ;
            [POS_TW_FIRST:POS_TW_LAST]:  rsp_next.out_byte = 8'(head.tuning_word >> tw_shift);
            POS_SHAPE_I:                 rsp_next.out_byte = INSTR_SHAPE_I;
            POS_SHAPE_Q:                 rsp_next.out_byte = INSTR_SHAPE_Q;
            POS_AMP_HI_I, POS_AMP_HI_Q:  rsp_next.out_byte = amp_hi;
            POS_AMP_LO_I, POS_AMP_LO_Q:  rsp_next.out_byte = amp_lo;
            default:                     rsp_next.out_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = head_valid;
        end
        if (emit)
        begin
            idx_next = (idx_reg == POS_LAST) ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // A pending last byte means the index has already wrapped
    a_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.frame_end) |-> idx_reg == '0)
        else $error("frame_end shown but index not wrapped");

    // The first byte of every frame is the frequency instruction
    a_first_instr: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && idx_reg == POS_FREQ_INSTR) |=> rsp_reg.out_byte == INSTR_FREQ)
        else $error("frame does not open with frequency instruction");
`endif

endmodule

[rtl/dds_tuning_word_frame_builder.sv]
// A request beat is registered in the front end, written into the frame queue, then
//   loaded byte by byte into the response register: 13 response beats per request,
//   one per cycle while rsp_ready holds; the one-byte-wide output sets the pace.
// The 2-entry frame queue lets the front end take the next request mid-frame.
// Reset (rst_n, async, active low) empties the queue, clears all valids and the
//   byte index, and loads the step-factor register with 938250.
module dds_tuning_word_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  dtwfb_pkg::req_t                req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output dtwfb_pkg::rsp_t                rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dtwfb_pkg::STEP_W-1:0]   cfg_data
);
    import dtwfb_pkg::*;

    // Front -> queue
    logic   push_valid;
    logic   push_ready;
    frame_t push_data;

    // Queue -> back
    logic   head_valid;
    logic   head_pop;
    frame_t head;

    // Front: registers the request beat, multiplies by the step factor
    // (32 x 24, low 48 bits kept) on the way into the queue.
    dtwfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Frames waiting for the serializer side
    dtwfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head)
    );

    // Back: 13-byte sequencer, head frame popped on its last byte so frames
    // run back to back with no gap.
    dtwfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head       (head),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the DDS tuning-word frame builder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtwfb_pkg::*;

    localparam int FRAME_BYTES     = 13;
    localparam int LONG_HOLD_BEATS = 150;  // receiver hold-off, long enough to fill the queue
    localparam int PHASE_ITEMS     = 50;
    localparam int NUM_PHASES      = 6;

    // One directed row. When has_word is set the tuning word is typed in
    // from hand arithmetic; otherwise the predictor supplies it.
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
        logic              has_word;
        logic [TW_W-1:0]   word;
    } directed_row_t;

    localparam int NUM_DIRECTED = 15;

    // Corners: zero and all-ones frequency, unit frequency (word equals the
    // step factor), the widest product wrapping past 48 bits, zero and unit
    // step factors, amplitude high nibble at 0 and 15, alternating bit patterns.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{STEP_RESET,   32'h0000_0000, 12'h000, 1'b1, 48'h0},
        '{STEP_RESET,   32'h0000_0001, 12'hFFF, 1'b1, 48'h0000_000E_510A},
        '{STEP_RESET,   32'hFFFF_FFFF, 12'hA5A, 1'b0, 48'h0},
        '{STEP_RESET,   32'd100000000, 12'h800, 1'b0, 48'h0},
        '{STEP_RESET,   32'h8000_0000, 12'h0FF, 1'b0, 48'h0},
        '{24'hFF_FFFF,  32'hFFFF_FFFF, 12'hFFF, 1'b1, 48'hFFFE_FF00_0001},
        '{24'hFF_FFFF,  32'h0000_0001, 12'h100, 1'b1, 48'h0000_00FF_FFFF},
        '{24'hFF_FFFF,  32'h1234_5678, 12'h555, 1'b0, 48'h0},
        '{24'h00_0000,  32'hFFFF_FFFF, 12'hAAA, 1'b1, 48'h0},
        '{24'h00_0000,  32'hDEAD_BEEF, 12'h001, 1'b1, 48'h0},
        '{24'h00_0001,  32'hFFFF_FFFF, 12'hF00, 1'b1, 48'h0000_FFFF_FFFF},
        '{24'h00_0001,  32'h0000_0000, 12'h0F0, 1'b1, 48'h0},
        '{24'h80_0000,  32'hFFFF_FFFF, 12'h00F, 1'b0, 48'h0},
        '{24'hAA_AAAA,  32'h5555_5555, 12'h555, 1'b0, 48'h0},
        '{24'h55_5555,  32'hAAAA_AAAA, 12'hAAA, 1'b0, 48'h0}
    };

    // DUT signals; every input starts at a known value
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [STEP_W-1:0] cfg_data  = '0;

    // Side info travelling with the request beat
    logic              beat_has_word = 1'b0;
    logic [TW_W-1:0]   beat_word     = '0;

    // Predictor state: step factor as the block should hold it
    logic [STEP_W-1:0] step_factor = STEP_RESET;

    // Bytes still owed by the block, oldest first
    rsp_t frame_bytes_owed [$];

    int  mismatches    = 0;
    bit  tx_bursts_on  = 1'b1;
    bit  rx_bursts_on  = 1'b1;
    bit  long_hold     = 1'b0;

    dds_tuning_word_frame_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Exact 56-bit product cut to the low 48 bits; wraps on overflow
    function automatic logic [TW_W-1:0] tuning_word_for(input logic [FREQ_W-1:0] f,
                                                        input logic [STEP_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = {{STEP_W{1'b0}}, f} * {{FREQ_W{1'b0}}, s};
        return prod[TW_W-1:0];
    endfunction

    // Lay out one 13-byte frame and append it to the owed bytes
    function automatic void owe_frame(input logic [TW_W-1:0] word,
                                      input logic [AMP_W-1:0] amp);
        logic [7:0] frame [FRAME_BYTES];
        rsp_t       beat;
        frame[POS_FREQ_INSTR] = INSTR_FREQ;
        for (int i = 0; i < 6; i++)
            frame[int'(POS_TW_FIRST) + i] = word[TW_W-1-8*i -: 8];
        frame[POS_SHAPE_I]  = INSTR_SHAPE_I;
        frame[POS_AMP_HI_I] = {4'b0, amp[11:8]};   // high byte only ever 0..15
        frame[POS_AMP_LO_I] = amp[7:0];
        frame[POS_SHAPE_Q]  = INSTR_SHAPE_Q;
        frame[POS_AMP_HI_Q] = {4'b0, amp[11:8]};
        frame[POS_AMP_LO_Q] = amp[7:0];
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            beat.out_byte  = frame[i];
            beat.frame_end = (i == int'(POS_LAST));
            frame_bytes_owed.push_back(beat);
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Scoreboard: sample every handshake at the rising edge.
    // Response is checked before a new frame is queued; the block's latency
    // means a same-cycle request can never owe the byte being checked.
    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (frame_bytes_owed.size() == 0)
                begin
                    report_mismatch("unexpected beat (out_byte)", 64'hx, 64'(rsp.out_byte));
                end
                else
                begin
                    want = frame_bytes_owed.pop_front();
                    if (rsp.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(want.out_byte), 64'(rsp.out_byte));
                    if (rsp.frame_end !== want.frame_end)
                        report_mismatch("frame_end", 64'(want.frame_end), 64'(rsp.frame_end));
                end
            end
            if (req_valid && req_ready)
                owe_frame(beat_has_word ? beat_word
                                        : tuning_word_for(req.frequency, step_factor),
                          req.amplitude);
            if (cfg_valid && cfg_ready)
                step_factor <= cfg_data;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, and
    // steady ready once bursts are switched off.
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD_BEATS) @(negedge clk);
                long_hold = 1'b0;
                rsp_ready <= 1'b1;
            end
            else if (rx_bursts_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Present one request beat and hold it until taken
    task automatic send_request(input logic [FREQ_W-1:0] f, input logic [AMP_W-1:0] a,
                                input logic has_word, input logic [TW_W-1:0] word);
        @(negedge clk);
        req_valid     <= 1'b1;
        req           <= '{frequency: f, amplitude: a};
        beat_has_word <= has_word;
        beat_word     <= word;
        do @(posedge clk); while (!(req_valid && req_ready));
    endtask

    // Now and then, the sender idles before its next request
    task automatic maybe_idle_sender();
        int gap;
        if (tx_bursts_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering, then wait for every owed byte and a short slack after it
    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (frame_bytes_owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_step_factor(input logic [STEP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly full-range words, plus small, near-max, single-bit and
    // realistic output frequencies
    function automatic logic [FREQ_W-1:0] random_frequency();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            6:       return FREQ_W'($urandom_range(0, 1000));
            7:       return 32'hFFFF_FFFF - FREQ_W'($urandom_range(0, 255));
            8:       return 32'h1 << $urandom_range(0, 31);
            9:       return FREQ_W'($urandom_range(1, 200000000));
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic logic [AMP_W-1:0] random_amplitude();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0:       return '0;
            1:       return '1;
            default: return AMP_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] phase_step_factor(input int phase);
        case (phase)
            1:       return 24'hFF_FFFF;
            2:       return '0;
            4:       return STEP_RESET;
            default: return STEP_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; first rows run on the reset step factor
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (directed_rows[r].step != step_factor)
            begin
                wait_idle();
                write_step_factor(directed_rows[r].step);
            end
            maybe_idle_sender();
            send_request(directed_rows[r].frequency, directed_rows[r].amplitude,
                         directed_rows[r].has_word, directed_rows[r].word);
        end

        // Random phases, each under its own step factor.
        //   phase 1: sender never idles, receiver holds off long -> input stalls
        //   phase 3: sender drains completely halfway through
        //   last phase: no idling on either side
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_step_factor(phase_step_factor(p));
            tx_bursts_on = (p != 1) && (p != NUM_PHASES - 1);
            rx_bursts_on = (p != NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == 5)
                    long_hold = 1'b1;
                if (p == 3 && n == PHASE_ITEMS / 2)
                    wait_idle();
                maybe_idle_sender();
                send_request(random_frequency(), random_amplitude(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
